### rtl/tree_partition_inverse_transform_macros.svh
// assertion macros used by the checker file
`ifndef TREE_PARTITION_INVERSE_TRANSFORM_MACROS_SVH
`define TREE_PARTITION_INVERSE_TRANSFORM_MACROS_SVH

// plain clocked property, reset gated
`define TPIT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tpit assertion failed");

// signal holds while a condition stands in the cycle before
`define TPIT_HOLD(lbl, clk, rst_n, cond, sig) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error("tpit hold assertion failed");

`endif

### rtl/tpit_pkg.sv
// ----------------------------------------------------------------------------
// tpit_pkg
// shared types and constants of the partition tree inverse transform
// ----------------------------------------------------------------------------
package tpit_pkg;

    localparam logic [1:0] OP_BOX   = 2'd0;
    localparam logic [1:0] OP_LINK  = 2'd1;
    localparam logic [1:0] OP_POINT = 2'd2;

    localparam logic [24:0] Q24_ONE = 25'h100_0000;

    // divider widths: numerator, denominator, quotient (all signed)
    localparam int DIV_NW = 58;
    localparam int DIV_DW = 34;
    localparam int DIV_QW = 59;

    typedef struct packed {
        logic [1:0]         operation;
        logic [7:0]         node_index;
        logic [1:0]         dim_index;
        logic signed [31:0] lower_bound;
        logic signed [31:0] upper_bound;
        logic [7:0]         left_child;
        logic               has_children;
        logic [24:0]        split_fraction;
        logic signed [31:0] coordinate;
        logic               last_coordinate;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] mapped_coordinate;
        logic               last_of_point;
    } t_out_item;

    typedef struct packed {
        logic                     start;
        logic signed [DIV_NW-1:0] num;
        logic signed [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic signed [DIV_QW-1:0] quo;
    } t_div_rsp;

endpackage

### rtl/tree_partition_inverse_transform.sv
// ----------------------------------------------------------------------------
// tree_partition_inverse_transform
// maps a point back through the inner nodes of a stored partition tree
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  in        input      i_in_valid / o_in_stall      t_in_item  (loads, coordinates)
//  out       output     o_out_valid / i_out_stall    t_out_item (mapped coordinates)
//
//  after the last coordinate the sequencer walks all NODES nodes: a leaf is
//  skipped, an inner node reads its child link, its DIMS box rows and the
//  child rows per split dimension probe, and a mapped node adds two divider passes
//  the DIMS results then leave one per cycle; a stalled result holds in the
//  output register and the input side stays stalled until the point is out
//  reset clears the split flags, the point buffer and the control state; the
//  table memories are undefined until loaded
module tree_partition_inverse_transform #(
    parameter int NODES = 255,
    parameter int DIMS  = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tpit_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tpit_pkg::t_out_item o_out_data
);
    import tpit_pkg::*;

    localparam int TDEPTH = NODES * DIMS;
    localparam int TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
    localparam int NAW    = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int NCW    = $clog2(NODES + 1);
    localparam int KW     = (DIMS > 1) ? $clog2(DIMS) : 1;
    localparam int CCW    = $clog2(DIMS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_NODE, S_CHILD, S_BOX, S_SPL_L, S_SPL_R,
        S_PROD, S_CMP, S_DIV_T, S_PROD2, S_DIV_Y, S_EMIT
    } t_state;

    function automatic logic [TAW-1:0] tab_addr(input int node, input int dim);
        return TAW'(node * DIMS + dim);
    endfunction

    // control
    t_state              r_state;
    logic [NCW-1:0]      r_j;
    logic [KW-1:0]       r_k;
    logic [KW-1:0]       r_d;
    logic [KW-1:0]       r_e;
    logic [CCW-1:0]      r_count;
    logic [NODES-1:0]    r_flags;
    logic                r_left;
    logic                r_out_valid;
    t_div_req            r_div_req;

    // payload
    logic [7:0]          r_lc;
    logic signed [31:0]  r_a;
    logic signed [31:0]  r_b;
    logic signed [31:0]  r_c;
    logic [24:0]         r_theta;
    logic [24:0]         r_t;
    logic signed [57:0]  r_lhs;
    logic signed [57:0]  r_rhs;
    logic signed [33:0]  r_ba;
    logic signed [31:0]  r_x [DIMS];
    t_out_item           r_out;

    // memory ports
    logic                box_we;
    logic                link_we;
    logic [TAW-1:0]      box_waddr;
    logic [NAW-1:0]      link_waddr;
    logic                tab_re;
    logic [TAW-1:0]      tab_raddr;
    logic                child_re;
    logic                frac_re;
    logic [NAW-1:0]      node_raddr;
    logic [31:0]         lower_q;
    logic [31:0]         upper_q;
    logic [7:0]          child_q;
    logic [24:0]         frac_q;
    t_div_rsp            div_rsp;

    // datapath terms
    logic                in_xfer;
    logic                j_node;
    logic                flag_j;
    logic                child_ok;
    logic                box_pass;
    logic                k_last;
    logic                spl_diff;
    logic signed [31:0]  cur_x;
    logic [24:0]         theta_c;
    logic signed [32:0]  ya;
    logic signed [32:0]  ba;
    logic signed [32:0]  ca;
    logic signed [32:0]  bc;
    logic signed [25:0]  tt;
    logic signed [58:0]  rhs_full;
    logic signed [58:0]  left_full;
    logic signed [58:0]  right_full;
    logic signed [59:0]  y_sum;
    logic signed [31:0]  y_new;
    logic [KW-1:0]       e_nx;

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign box_we     = in_xfer && (i_in_data.operation == OP_BOX)
                        && (int'(i_in_data.node_index) < NODES)
                        && (int'(i_in_data.dim_index) < DIMS);
    assign link_we    = in_xfer && (i_in_data.operation == OP_LINK)
                        && (int'(i_in_data.node_index) < NODES);
    assign box_waddr  = tab_addr(int'(i_in_data.node_index), int'(i_in_data.dim_index));
    assign link_waddr = NAW'(i_in_data.node_index);

    assign j_node   = r_j < NCW'(NODES);
    assign flag_j   = j_node && r_flags[r_j[NAW-1:0]];
    // a bad link (either child past the end) makes the node a leaf
    assign child_ok = (int'(child_q) + 1) < NODES;
    assign cur_x    = r_x[r_k];
    // open below, closed above
    assign box_pass = ($signed(lower_q) < cur_x) && (cur_x <= $signed(upper_q));
    assign k_last   = int'(r_k) == (DIMS - 1);
    assign spl_diff = $signed(lower_q) != r_a;
    assign e_nx     = KW'(int'(r_e) + 1);

    // read address sequencing, data comes back in the next cycle
    always_comb begin
        tab_re     = 1'b0;
        tab_raddr  = '0;
        child_re   = 1'b0;
        frac_re    = 1'b0;
        node_raddr = r_j[NAW-1:0];
        unique case (r_state)
            S_NODE: begin
                child_re = flag_j;
            end
            S_CHILD: begin
                tab_re    = child_ok;
                tab_raddr = tab_addr(int'(r_j), 0);
            end
            S_BOX: begin
                if (box_pass && !k_last) begin
                    tab_re    = 1'b1;
                    tab_raddr = tab_addr(int'(r_j), int'(r_k) + 1);
                end else if (box_pass) begin
                    tab_re     = 1'b1;
                    tab_raddr  = tab_addr(int'(r_lc), 0);
                    frac_re    = 1'b1;
                    node_raddr = NAW'(r_lc);
                end
            end
            S_SPL_L: begin
                tab_re    = 1'b1;
                tab_raddr = tab_addr(int'(r_lc) + 1, int'(r_k));
            end
            S_SPL_R: begin
                if (!spl_diff && !k_last) begin
                    tab_re    = 1'b1;
                    tab_raddr = tab_addr(int'(r_lc), int'(r_k) + 1);
                end
            end
            default: begin
                tab_re = 1'b0;
            end
        endcase
    end

    // arithmetic terms
    assign theta_c    = (frac_q > Q24_ONE) ? Q24_ONE : frac_q;
    assign ya         = {r_x[r_d][31], r_x[r_d]} - {r_a[31], r_a};
    assign ba         = {r_b[31], r_b} - {r_a[31], r_a};
    assign ca         = {r_c[31], r_c} - {r_a[31], r_a};
    assign bc         = {r_b[31], r_b} - {r_c[31], r_c};
    assign tt         = $signed({1'b0, r_t}) - $signed({1'b0, r_theta});
    assign rhs_full   = $signed({1'b0, theta_c}) * ba;
    assign left_full  = ca * $signed({1'b0, r_t});
    assign right_full = bc * tt;
    assign y_sum      = 60'(div_rsp.quo) + 60'(r_left ? r_a : r_c);
    always_comb begin
        if (y_sum > 60'sd2147483647) begin
            y_new = 32'sh7FFF_FFFF;
        end else if (y_sum < -60'sd2147483648) begin
            y_new = 32'sh8000_0000;
        end else begin
            y_new = y_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_j         <= '0;
            r_k         <= '0;
            r_e         <= '0;
            r_count     <= '0;
            r_flags     <= '0;
            r_out_valid <= 1'b0;
            r_div_req   <= '0;
            for (int i = 0; i < DIMS; i++) begin
                r_x[i] <= '0;
            end
        end else begin
            r_div_req.start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (link_we) begin
                        r_flags[link_waddr] <= i_in_data.has_children;
                    end
                    if (in_xfer && (i_in_data.operation == OP_POINT)) begin
                        // extra coordinates beyond DIMS are dropped
                        if (int'(r_count) < DIMS) begin
                            r_x[KW'(r_count)] <= i_in_data.coordinate;
                            r_count           <= r_count + 1'b1;
                        end
                        if (i_in_data.last_coordinate) begin
                            r_j     <= '0;
                            r_state <= S_NODE;
                        end
                    end
                end
                S_NODE: begin
                    if (!j_node) begin
                        r_out.mapped_coordinate <= r_x[0];
                        r_out.last_of_point     <= (DIMS == 1);
                        r_out_valid             <= 1'b1;
                        r_e                     <= '0;
                        r_state                 <= S_EMIT;
                    end else if (flag_j) begin
                        r_state <= S_CHILD;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_CHILD: begin
                    if (child_ok) begin
                        r_lc    <= child_q;
                        r_k     <= '0;
                        r_state <= S_BOX;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_NODE;
                    end
                end
                S_BOX: begin
                    if (!box_pass) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_NODE;
                    end else if (k_last) begin
                        r_k     <= '0;
                        r_state <= S_SPL_L;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_SPL_L: begin
                    r_a     <= $signed(lower_q);
                    r_c     <= $signed(upper_q);
                    r_state <= S_SPL_R;
                end
                S_SPL_R: begin
                    // split dimension: first one where the child lower bounds differ
                    if (spl_diff) begin
                        r_b     <= $signed(upper_q);
                        r_d     <= r_k;
                        r_state <= S_PROD;
                    end else if (k_last) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_NODE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_SPL_L;
                    end
                end
                S_PROD: begin
                    r_theta <= theta_c;
                    r_lhs   <= {ya[32], ya, 24'b0};
                    r_rhs   <= rhs_full[57:0];
                    r_ba    <= 34'(ba);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    // exactly on mid leaves the coordinate as it is
                    if (r_lhs == r_rhs) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_NODE;
                    end else begin
                        r_left          <= r_lhs < r_rhs;
                        r_div_req.start <= 1'b1;
                        r_div_req.num   <= r_lhs;
                        r_div_req.den   <= r_ba;
                        r_state         <= S_DIV_T;
                    end
                end
                S_DIV_T: begin
                    if (div_rsp.done) begin
                        if (div_rsp.quo < 0) begin
                            r_t <= '0;
                        end else if (div_rsp.quo > $signed({34'b0, Q24_ONE})) begin
                            r_t <= Q24_ONE;
                        end else begin
                            r_t <= div_rsp.quo[24:0];
                        end
                        r_state <= S_PROD2;
                    end
                end
                S_PROD2: begin
                    r_div_req.start <= 1'b1;
                    if (r_left) begin
                        r_div_req.num <= left_full[57:0];
                        r_div_req.den <= 34'({1'b0, r_theta});
                    end else begin
                        r_div_req.num <= right_full[57:0];
                        r_div_req.den <= 34'({1'b0, Q24_ONE - r_theta});
                    end
                    r_state <= S_DIV_Y;
                end
                S_DIV_Y: begin
                    if (div_rsp.done) begin
                        r_x[r_d] <= y_new;
                        r_j      <= r_j + 1'b1;
                        r_state  <= S_NODE;
                    end
                end
                S_EMIT: begin
                    if (!i_out_stall) begin
                        if (int'(r_e) == DIMS - 1) begin
                            // point done: buffer back to zero for the next one
                            r_out_valid <= 1'b0;
                            r_count     <= '0;
                            for (int i = 0; i < DIMS; i++) begin
                                r_x[i] <= '0;
                            end
                            r_state <= S_IDLE;
                        end else begin
                            r_e                     <= e_nx;
                            r_out.mapped_coordinate <= r_x[e_nx];
                            r_out.last_of_point     <= (int'(e_nx) == DIMS - 1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    tpit_ram #(.WIDTH(32), .DEPTH(TDEPTH)) u_lower (
        .i_clk   (i_clk),
        .i_we    (box_we),
        .i_waddr (box_waddr),
        .i_wdata (i_in_data.lower_bound),
        .i_re    (tab_re),
        .i_raddr (tab_raddr),
        .o_rdata (lower_q)
    );

    tpit_ram #(.WIDTH(32), .DEPTH(TDEPTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (box_we),
        .i_waddr (box_waddr),
        .i_wdata (i_in_data.upper_bound),
        .i_re    (tab_re),
        .i_raddr (tab_raddr),
        .o_rdata (upper_q)
    );

    tpit_ram #(.WIDTH(8), .DEPTH(NODES)) u_child (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (i_in_data.left_child),
        .i_re    (child_re),
        .i_raddr (node_raddr),
        .o_rdata (child_q)
    );

    tpit_ram #(.WIDTH(25), .DEPTH(NODES)) u_frac (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (i_in_data.split_fraction),
        .i_re    (frac_re),
        .i_raddr (node_raddr),
        .o_rdata (frac_q)
    );

    tpit_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (div_rsp)
    );

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

### rtl/tpit_ram.sv
// ----------------------------------------------------------------------------
// tpit_ram
// single write port, single registered read port memory
// ----------------------------------------------------------------------------
module tpit_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1020,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/tpit_div.sv
// ----------------------------------------------------------------------------
// tpit_div
// signed restoring divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module tpit_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tpit_pkg::t_div_req i_req,
    output tpit_pkg::t_div_rsp o_rsp
);
    import tpit_pkg::*;

    localparam int CW = $clog2(DIV_NW + 1);

    typedef enum logic {D_IDLE, D_RUN} t_dstate;

    t_dstate                  r_state;
    logic [CW-1:0]            r_cnt;
    logic [DIV_DW-1:0]        r_rem;
    logic [DIV_NW-1:0]        r_quo;
    logic [DIV_DW-1:0]        r_dmag;
    logic                     r_neg;
    logic                     r_done;
    logic signed [DIV_QW-1:0] r_res;

    logic [DIV_DW:0]          rem_sh;
    logic                     ge;
    logic [DIV_DW:0]          rem_nx;
    logic [DIV_NW-1:0]        quo_nx;
    logic [DIV_NW-1:0]        nmag;
    logic [DIV_DW-1:0]        dmag;

    assign nmag   = i_req.num[DIV_NW-1] ? DIV_NW'(-i_req.num) : DIV_NW'(i_req.num);
    assign dmag   = i_req.den[DIV_DW-1] ? DIV_DW'(-i_req.den) : DIV_DW'(i_req.den);
    assign rem_sh = {r_rem, r_quo[DIV_NW-1]};
    assign ge     = rem_sh >= {1'b0, r_dmag};
    assign rem_nx = ge ? (rem_sh - {1'b0, r_dmag}) : rem_sh;
    assign quo_nx = {r_quo[DIV_NW-2:0], ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_req.start) begin
                        if (i_req.den == '0) begin
                            // zero divisor saturates toward the numerator sign
                            if (i_req.num > 0) begin
                                r_res <= {1'b0, {(DIV_QW-1){1'b1}}};
                            end else if (i_req.num < 0) begin
                                r_res <= {1'b1, {(DIV_QW-2){1'b0}}, 1'b1};
                            end else begin
                                r_res <= '0;
                            end
                            r_done <= 1'b1;
                        end else begin
                            r_rem   <= '0;
                            r_quo   <= nmag;
                            r_dmag  <= dmag;
                            r_neg   <= i_req.num[DIV_NW-1] ^ i_req.den[DIV_DW-1];
                            r_cnt   <= CW'(DIV_NW);
                            r_state <= D_RUN;
                        end
                    end
                end
                D_RUN: begin
                    r_rem <= rem_nx[DIV_DW-1:0];
                    r_quo <= quo_nx;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        r_res   <= r_neg ? -$signed({1'b0, quo_nx}) : $signed({1'b0, quo_nx});
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_res;
endmodule

### rtl/tpit_checker.sv
// ----------------------------------------------------------------------------
// tpit_checker
// port level checks of the inverse transform, bound to the top level
// ----------------------------------------------------------------------------
`include "tree_partition_inverse_transform_macros.svh"

module tpit_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input tpit_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input tpit_pkg::t_out_item o_out_data
);
    import tpit_pkg::*;

    logic last_xfer;
    assign last_xfer = i_in_valid && !o_in_stall && (i_in_data.operation == OP_POINT)
                       && i_in_data.last_coordinate;

    `TPIT_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> o_out_valid)
    `TPIT_HOLD(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_data)
    `TPIT_ASSERT(a_busy_emit, i_clk, i_rst_n, o_out_valid |-> o_in_stall)
    `TPIT_ASSERT(a_walk_start, i_clk, i_rst_n, last_xfer |=> (o_in_stall && !o_out_valid))
endmodule

bind tree_partition_inverse_transform tpit_checker u_tpit_checker (.*);
